@@ src/mandelbrot_escape_pixel_assert.svh @@
// ----------------------------------------------------------------------------
// Assertion macros for the Mandelbrot escape pixel engine
// Concurrent assertion wrappers that compile away when SYNTHESIS is defined.
// ----------------------------------------------------------------------------
`ifndef MANDELBROT_ESCAPE_PIXEL_ASSERT_SVH
`define MANDELBROT_ESCAPE_PIXEL_ASSERT_SVH

`ifndef SYNTHESIS

`define MBE_ASSERT_IMP(lbl, clk, rstn, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!(rstn)) (ante) |-> (cons)) \
    else $error("mbe assertion failed");

`define MBE_ASSERT_NXT(lbl, clk, rstn, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!(rstn)) (ante) |=> (cons)) \
    else $error("mbe assertion failed");

`else

`define MBE_ASSERT_IMP(lbl, clk, rstn, ante, cons)

`define MBE_ASSERT_NXT(lbl, clk, rstn, ante, cons)

`endif

`endif

@@ src/mbe_pkg.sv @@
// ----------------------------------------------------------------------------
// Mandelbrot escape package
// Shared widths, constants, register indexes, the iteration token and helpers.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

package mbe_pkg;

  localparam int IMAGE_DIM = 1024;
  localparam int FRAC_BITS = 28;
  localparam int DATA_W    = 32;
  localparam int IDX_W     = 10;
  localparam int CNT_W     = 12;
  localparam int CLS_W     = 2;
  localparam int CFG_IDX_W = 3;
  localparam int MBE_CELLS = 4;
  localparam int PROD_W    = IDX_W + 1 + DATA_W;

  localparam logic signed [63:0] SAT_MAX = 64'sh0000_0000_7FFF_FFFF;
  localparam logic signed [63:0] SAT_MIN = 64'shFFFF_FFFF_8000_0000;
  localparam logic signed [63:0] FOUR    = 64'sd4 <<< FRAC_BITS;

  // Reciprocal of three for a 12-bit dividend: floor(n / 3) = (n * 2731) >> 13.
  localparam logic [CNT_W:0] THIRD_MUL   = 13'd2731;
  localparam int             THIRD_SHIFT = 13;

  localparam logic [CFG_IDX_W-1:0] REG_ORIGIN_X = 3'd0;
  localparam logic [CFG_IDX_W-1:0] REG_ORIGIN_Y = 3'd1;
  localparam logic [CFG_IDX_W-1:0] REG_STEP_X   = 3'd2;
  localparam logic [CFG_IDX_W-1:0] REG_STEP_Y   = 3'd3;
  localparam logic [CFG_IDX_W-1:0] REG_LIMIT    = 3'd4;

  localparam logic [CLS_W-1:0] CLS_BLACK = 2'd0;
  localparam logic [CLS_W-1:0] CLS_WHITE = 2'd1;
  localparam logic [CLS_W-1:0] CLS_GREEN = 2'd2;
  localparam logic [CLS_W-1:0] CLS_BLUE  = 2'd3;

  typedef struct packed {
    logic                     valid;
    logic                     done;
    logic [CNT_W-1:0]         count;
    logic signed [DATA_W-1:0] zx;
    logic signed [DATA_W-1:0] zy;
    logic signed [DATA_W-1:0] cx;
    logic signed [DATA_W-1:0] cy;
  } mbe_token_t;

  function automatic logic signed [63:0] sx64(input logic [DATA_W-1:0] v);
    return $signed({{(64 - DATA_W){v[DATA_W-1]}}, v});
  endfunction

  function automatic logic signed [DATA_W-1:0] sat32(input logic signed [63:0] v);
    logic signed [DATA_W-1:0] r;
    if (v > SAT_MAX) begin
      r = SAT_MAX[DATA_W-1:0];
    end else if (v < SAT_MIN) begin
      r = SAT_MIN[DATA_W-1:0];
    end else begin
      r = v[DATA_W-1:0];
    end
    return r;
  endfunction

  function automatic logic [IDX_W-1:0] clamp_idx(input logic [IDX_W-1:0] idx);
    logic [IDX_W-1:0] r;
    if (32'(idx) >= IMAGE_DIM) begin
      r = IDX_W'(IMAGE_DIM - 1);
    end else begin
      r = idx;
    end
    return r;
  endfunction

endpackage

@@ src/mbe_if.sv @@
// ----------------------------------------------------------------------------
// Mandelbrot escape channels
// Valid/ready channels for pixel requests and escape results.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

interface mbe_pix_if import mbe_pkg::*; ();
  logic             valid;
  logic             ready;
  logic [IDX_W-1:0] pixel_col;
  logic [IDX_W-1:0] pixel_row;

  modport source (output valid, output pixel_col, output pixel_row, input ready);
  modport sink (input valid, input pixel_col, input pixel_row, output ready);
endinterface

interface mbe_res_if import mbe_pkg::*; ();
  logic             valid;
  logic             ready;
  logic [CNT_W-1:0] escape_count;
  logic [CLS_W-1:0] color_class;

  modport source (output valid, output escape_count, output color_class, input ready);
  modport sink (input valid, input escape_count, input color_class, output ready);
endinterface

@@ src/mbe_cell.sv @@
// ----------------------------------------------------------------------------
// Mandelbrot escape cell
// One iteration of z = z^2 + c in two register stages, handed to the neighbor.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module mbe_cell import mbe_pkg::*; (
  input  logic             clk,
  input  logic             rst_n,
  input  logic [CNT_W-1:0] limit,
  input  mbe_token_t       tok_in,
  output mbe_token_t       tok_out
);

  logic              a_valid_r;
  mbe_token_t        a_tok_r;
  logic signed [63:0] pxx_r;
  logic signed [63:0] pyy_r;
  logic signed [63:0] pxy_r;
  mbe_token_t        tok_r;
  mbe_token_t        tok_nxt;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      a_valid_r <= 1'b0;
    end else begin
      a_valid_r <= tok_in.valid;
    end
  end

  always_ff @(posedge clk) begin
    a_tok_r <= tok_in;
    pxx_r   <= $signed(tok_in.zx) * $signed(tok_in.zx);
    pyy_r   <= $signed(tok_in.zy) * $signed(tok_in.zy);
    pxy_r   <= $signed(tok_in.zx) * $signed(tok_in.zy);
  end

  always_comb begin
    logic signed [DATA_W-1:0] x2;
    logic signed [DATA_W-1:0] y2;
    logic signed [DATA_W-1:0] xy2;
    logic signed [63:0]       mag;
    x2  = sat32(pxx_r >>> FRAC_BITS);
    y2  = sat32(pyy_r >>> FRAC_BITS);
    xy2 = sat32(pxy_r >>> (FRAC_BITS - 1));
    mag = sx64(x2) + sx64(y2);
    tok_nxt       = a_tok_r;
    tok_nxt.valid = a_valid_r;
    if (!a_tok_r.done) begin
      if ((a_tok_r.count >= limit) || (mag > FOUR)) begin
        tok_nxt.done = 1'b1;
      end else begin
        tok_nxt.zy    = sat32(sx64(xy2) + sx64(a_tok_r.cy));
        tok_nxt.zx    = sat32(sx64(x2) - sx64(y2) + sx64(a_tok_r.cx));
        tok_nxt.count = a_tok_r.count + CNT_W'(1);
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      tok_r <= '0;
    end else begin
      tok_r <= tok_nxt;
    end
  end

  assign tok_out = tok_r;

endmodule

@@ src/mandelbrot_escape_pixel.sv @@
// ----------------------------------------------------------------------------
// Mandelbrot escape pixel engine
// Maps a pixel to c in signed Q4.28, iterates z = z^2 + c and classifies the
// escape count against the configured iteration limit.
// ----------------------------------------------------------------------------
// One pixel is in flight at a time. Its token circles a ring of four cells,
// each cell doing one iteration in two register stages. A result is
// captured when the token leaves the last cell marked done, and the next
// pixel can be taken in the same cycle that the result becomes valid. A
// result that finds the output register still occupied keeps circling the
// ring until the output register can take it.
`timescale 1ns / 1ps
`include "mandelbrot_escape_pixel_assert.svh"

module mandelbrot_escape_pixel import mbe_pkg::*; (
  input  logic                 clk,
  input  logic                 rst_n,
  mbe_pix_if.sink              in_ch,
  mbe_res_if.source            out_ch,
  input  logic                 cfg_we,
  input  logic [CFG_IDX_W-1:0] cfg_index,
  input  logic [DATA_W-1:0]    cfg_wdata
);

  typedef enum logic [2:0] {
    ST_IDLE  = 3'b001,
    ST_COORD = 3'b010,
    ST_RUN   = 3'b100
  } state_t;

  state_t                   state_r;
  state_t                   state_nxt;
  logic signed [DATA_W-1:0] origin_x_r;
  logic signed [DATA_W-1:0] origin_y_r;
  logic signed [DATA_W-1:0] step_x_r;
  logic signed [DATA_W-1:0] step_y_r;
  logic [CNT_W-1:0]         limit_r;
  logic signed [PROD_W-1:0] prod_x_r;
  logic signed [PROD_W-1:0] prod_y_r;
  logic [CNT_W-1:0]         third_r;
  logic [CNT_W-1:0]         third_nxt;
  logic [2*CNT_W:0]         third_prod;
  logic                     out_valid_r;
  logic [CNT_W-1:0]         out_count_r;
  logic [CLS_W-1:0]         out_class_r;
  logic [CLS_W-1:0]         class_nxt;
  logic                     in_xfer;
  logic                     capture;
  mbe_token_t               head;
  mbe_token_t               last;
  mbe_token_t               ring [MBE_CELLS];
  logic [MBE_CELLS-1:0]     ring_valid;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      origin_x_r <= -32'sd536870912;
      origin_y_r <= -32'sd268435456;
      step_x_r   <= 32'sd786432;
      step_y_r   <= 32'sd524288;
      limit_r    <= 12'd255;
    end else if (cfg_we) begin
      case (cfg_index)
        REG_ORIGIN_X: origin_x_r <= cfg_wdata;
        REG_ORIGIN_Y: origin_y_r <= cfg_wdata;
        REG_STEP_X:   step_x_r   <= cfg_wdata;
        REG_STEP_Y:   step_y_r   <= cfg_wdata;
        REG_LIMIT:    limit_r    <= cfg_wdata[CNT_W-1:0];
        default: begin
        end
      endcase
    end
  end

  assign in_ch.ready = (state_r == ST_IDLE);
  assign in_xfer     = in_ch.valid && in_ch.ready;
  assign last        = ring[MBE_CELLS-1];
  assign capture     = (state_r == ST_RUN) && last.valid && last.done &&
                       (!out_valid_r || out_ch.ready);

  assign third_prod = limit_r * THIRD_MUL;
  assign third_nxt  = CNT_W'(third_prod >> THIRD_SHIFT);

  always_ff @(posedge clk) begin
    if (in_xfer) begin
      prod_x_r <= $signed({1'b0, clamp_idx(in_ch.pixel_col)}) * step_x_r;
      prod_y_r <= $signed({1'b0, clamp_idx(in_ch.pixel_row)}) * step_y_r;
      third_r  <= third_nxt;
    end
  end

  always_comb begin
    state_nxt = state_r;
    case (state_r)
      ST_IDLE:  if (in_xfer) state_nxt = ST_COORD;
      ST_COORD: state_nxt = ST_RUN;
      ST_RUN:   if (capture) state_nxt = ST_IDLE;
      default:  state_nxt = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= ST_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

  always_comb begin
    head = last;
    if (state_r == ST_COORD) begin
      head.valid = 1'b1;
      head.done  = 1'b0;
      head.count = '0;
      head.zx    = '0;
      head.zy    = '0;
      head.cx    = sat32(sx64(origin_x_r) +
                         $signed({{(64 - PROD_W){prod_x_r[PROD_W-1]}}, prod_x_r}));
      head.cy    = sat32(sx64(origin_y_r) +
                         $signed({{(64 - PROD_W){prod_y_r[PROD_W-1]}}, prod_y_r}));
    end else begin
      head.valid = last.valid && !capture && (state_r == ST_RUN);
    end
  end

  genvar gi;
  generate
    for (gi = 0; gi < MBE_CELLS; gi++) begin : g_cell
      if (gi == 0) begin : g_first
        mbe_cell u_cell (
          .clk     (clk),
          .rst_n   (rst_n),
          .limit   (limit_r),
          .tok_in  (head),
          .tok_out (ring[gi])
        );
      end else begin : g_next
        mbe_cell u_cell (
          .clk     (clk),
          .rst_n   (rst_n),
          .limit   (limit_r),
          .tok_in  (ring[gi-1]),
          .tok_out (ring[gi])
        );
      end
      assign ring_valid[gi] = ring[gi].valid;
    end
  endgenerate

  always_comb begin
    if (last.count == limit_r) begin
      class_nxt = CLS_BLACK;
    end else if (last.count < third_r) begin
      class_nxt = CLS_WHITE;
    end else if ({1'b0, last.count} < {third_r, 1'b0}) begin
      class_nxt = CLS_GREEN;
    end else begin
      class_nxt = CLS_BLUE;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (capture) begin
      out_valid_r <= 1'b1;
    end else if (out_ch.ready) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (capture) begin
      out_count_r <= last.count;
      out_class_r <= class_nxt;
    end
  end

  assign out_ch.valid        = out_valid_r;
  assign out_ch.escape_count = out_count_r;
  assign out_ch.color_class  = out_class_r;

  `MBE_ASSERT_NXT(a_xfer_to_coord, clk, rst_n, in_xfer, state_r == ST_COORD)
  `MBE_ASSERT_IMP(a_one_token, clk, rst_n, 1'b1, $onehot0(ring_valid))
  `MBE_ASSERT_IMP(a_count_le_limit, clk, rst_n, out_valid_r, out_count_r <= limit_r)
  `MBE_ASSERT_IMP(a_black_iff_limit, clk, rst_n, out_valid_r, (out_class_r == CLS_BLACK) == (out_count_r == limit_r))

endmodule
